### hw/rtl/bfd_pkg.sv
package bfd_pkg;

    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned REF_W     = 27;
    localparam int unsigned CNT_W     = 24;
    localparam int unsigned MUL_W     = REF_W + 10;
    localparam int unsigned FREQ_W    = 61;
    localparam int unsigned STEP_W    = 6;

    localparam logic [REF_W-1:0]  REF_RESET = REF_W'(1000000);
    localparam logic [9:0]        MILLI     = 10'd1000;
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(CNT_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(FREQ_W - 1);

    typedef struct packed {
        logic [7:0]       header;
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] test;
    } t_frame;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/bfd_frame.sv
module bfd_frame
    import bfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_start,
    output t_frame     o_frame
);

    logic [7:0] r_hist [FRAME_LEN];
    logic [7:0] n_hist [FRAME_LEN];
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic [7:0] fr [FRAME_LEN];
    logic       marker;
    logic       full;

    assign marker = i_byte[0];
    assign full   = (r_count == 3'(FRAME_LEN));

    always_comb begin
        for (int k = 0; k < FRAME_LEN; k++) begin
            fr[k] = r_hist[k] | {7'd0, i_byte[7-k]};
        end
    end

    assign o_frame.header = fr[0];
    assign o_frame.base   = {fr[1], fr[2], fr[3]};
    assign o_frame.test   = {fr[4], fr[5], fr[6]};
    assign o_start        = i_accept && marker && full;

    always_comb begin
        n_hist  = r_hist;
        n_count = r_count;
        if (i_accept) begin
            if (marker) begin
                n_count = 3'd0;
            end else begin
                for (int k = 0; k < FRAME_LEN - 1; k++) begin
                    n_hist[k] = r_hist[k+1];
                end
                n_hist[FRAME_LEN-1] = i_byte;
                if (!full) begin
                    n_count = r_count + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                r_hist[k] <= 8'd0;
            end
            r_count <= 3'd0;
        end else begin
            r_hist  <= n_hist;
            r_count <= n_count;
        end
    end

endmodule

### hw/rtl/bfd_addsub.sv
module bfd_addsub
    import bfd_pkg::*;
(
    input  logic [FREQ_W-1:0] i_a,
    input  logic [FREQ_W-1:0] i_b,
    input  logic              i_sub,
    output logic [FREQ_W-1:0] o_sum,
    output logic              o_carry
);

    logic [FREQ_W-1:0] b_eff;

    // Subtraction is a + ~b + 1; a carry out means no borrow.
    assign b_eff = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, b_eff} + {{FREQ_W{1'b0}}, i_sub};

endmodule

### hw/rtl/bfd_engine.sv
module bfd_engine
    import bfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_frame            i_frame,
    input  logic [REF_W-1:0]  i_ref_hz,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [7:0]        o_header_byte,
    output logic [CNT_W-1:0]  o_base_cnt,
    output logic [CNT_W-1:0]  o_test_cnt,
    output logic [FREQ_W-1:0] o_freq_millihz,
    output logic              o_zero_base
);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [MUL_W-1:0]  r_m, n_m;
    logic [CNT_W-1:0]  r_t, n_t;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [FREQ_W-1:0] r_q, n_q;
    t_frame            r_frame, n_frame;
    logic              r_zero, n_zero;
    logic              load_out;

    logic [FREQ_W-1:0] au_a, au_b, au_sum;
    logic              au_sub, au_carry;
    logic [CNT_W:0]    trial;

    bfd_addsub u_addsub (
        .i_a     (au_a),
        .i_b     (au_b),
        .i_sub   (au_sub),
        .o_sum   (au_sum),
        .o_carry (au_carry)
    );

    assign trial  = {r_rem[CNT_W-1:0], r_q[FREQ_W-1]};
    assign o_idle = (r_state == ST_IDLE);

    always_comb begin
        au_a   = {r_q[FREQ_W-2:0], 1'b0};
        au_b   = r_t[CNT_W-1] ? FREQ_W'(r_m) : '0;
        au_sub = 1'b0;
        if (r_state == ST_DIV) begin
            au_a   = FREQ_W'(trial);
            au_b   = FREQ_W'(r_frame.base);
            au_sub = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_m      = r_m;
        n_t      = r_t;
        n_rem    = r_rem;
        n_q      = r_q;
        n_frame  = r_frame;
        n_zero   = r_zero;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_frame = i_frame;
                    n_m     = MUL_W'(i_ref_hz) * MUL_W'(MILLI);
                    n_t     = i_frame.test;
                    n_q     = '0;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_zero  = (i_frame.base == '0);
                    n_state = (i_frame.base == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                n_q = au_sum;
                n_t = {r_t[CNT_W-2:0], 1'b0};
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            ST_DIV: begin
                n_rem = au_carry ? au_sum[CNT_W:0] : trial;
                n_q   = {r_q[FREQ_W-2:0], au_carry};
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (!o_res_valid || i_res_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            o_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (load_out) begin
                o_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                o_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_t     <= n_t;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_frame <= n_frame;
        r_zero  <= n_zero;
        if (load_out) begin
            o_header_byte  <= r_frame.header;
            o_base_cnt     <= r_frame.base;
            o_test_cnt     <= r_frame.test;
            o_freq_millihz <= r_q;
            o_zero_base    <= r_zero;
        end
    end

    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_cnt <= MUL_LAST))
        else $error("multiply step count out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < {1'b0, r_frame.base}))
        else $error("division remainder not below divisor");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("frame started while engine busy");

    a_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_zero_base) |-> (o_freq_millihz == '0))
        else $error("zero base result with nonzero frequency");

endmodule

### hw/rtl/byte_frame_decoder_frequency_ratio.sv
// Byte frame decoder with frequency ratio. Received link bytes come in one word
// at a time on the rx channel. A byte with bit 0 clear is data and is shifted
// into a seven-byte history; a byte with bit 0 set is a frame marker whose bits
// 7 to 1 restore bit 0 of frame bytes 0 to 6. When at least seven data bytes
// preceded the marker, one result word is produced: the header byte, the base
// and test counts (big endian, 24 bits each) and the frequency
// ref_clock_hz*1000*test/base in milli-hertz, truncated; a zero base sets
// zero_base and reports a frequency of zero. A short frame is dropped silently.
// Data bytes are taken back to back while the engine is idle. A complete frame
// with a nonzero base goes from its marker to the next byte through taking the
// marker, 24 shift-add multiply steps, 61 restoring division steps and handing
// the result to the output register, all through a single shared 61-bit
// adder-subtractor; rx ready is low from the first multiply step through the
// hand-over. A zero base frame skips to the hand-over. The result sits in an
// output register, so the next bytes are taken while a result still waits
// downstream; if the following frame finishes before that result is taken, the
// hand-over cycle stretches, and rx stays not ready, until the output register
// is free. The configuration word ref_clock_hz (reset 1000000) is taken at any
// time but is meant to be written while no frame is in progress.
module byte_frame_decoder_frequency_ratio
    import bfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [7:0]        o_header_byte,
    output logic [23:0]       o_base_cnt,
    output logic [23:0]       o_test_cnt,
    output logic [60:0]       o_freq_millihz,
    output logic              o_zero_base,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [26:0]       i_cfg_data
);

    logic [REF_W-1:0] r_ref_hz;
    logic             rx_accept;
    logic             start;
    logic             idle;
    t_frame           frame;

    // The configuration word is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_hz <= REF_RESET;
        end else if (i_cfg_valid) begin
            r_ref_hz <= i_cfg_data;
        end
    end

    // Bytes are taken only while the arithmetic engine is idle.
    assign o_rx_ready = idle;
    assign rx_accept  = i_rx_valid && o_rx_ready;

    bfd_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (rx_accept),
        .i_byte   (i_rx_byte),
        .o_start  (start),
        .o_frame  (frame)
    );

    bfd_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_frame        (frame),
        .i_ref_hz       (r_ref_hz),
        .o_idle         (idle),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_header_byte  (o_header_byte),
        .o_base_cnt     (o_base_cnt),
        .o_test_cnt     (o_test_cnt),
        .o_freq_millihz (o_freq_millihz),
        .o_zero_base    (o_zero_base)
    );

endmodule
